### design/lpfcb_pkg.sv
`default_nettype none

package lpfcb_pkg;

  // Item opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PROBE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROGRESS_SPAN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROGRESS_SCALE = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic [7:0]  pulse_gain;
    logic [7:0]  brightness_ceiling;
    logic [7:0]  decay_step;
    logic [15:0] decay_interval;
    logic [15:0] progress_span;
    logic [7:0]  progress_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pulse_gain:         8'd32,
    brightness_ceiling: 8'd255,
    decay_step:         8'd1,
    decay_interval:     16'd10,
    progress_span:      16'd100,
    progress_scale:     8'd255
  };

  // Divider lanes: three color channels, then the progress value
  typedef logic [1:0] lane_t;
  localparam lane_t LANE_RED   = 2'd0;
  localparam lane_t LANE_GREEN = 2'd1;
  localparam lane_t LANE_BLUE  = 2'd2;
  localparam lane_t LANE_PROG  = 2'd3;

  // Two quotient bits per step, eight quotient bits per division
  typedef logic [1:0] step_t;
  localparam step_t STEP_LAST = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_LEVEL,
    S_MUL,
    S_DIV,
    S_STORE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  apply;
    logic  level_upd;
    logic  mul;
    logic  div_step;
    logic  div_first;
    logic  store;
    logic  emit;
    lane_t lane;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_probe;
  } dp_status_t;

endpackage

`default_nettype wire

### design/led_pulse_fade_color_blender.sv
// LED drive engine: one item in, one result beat out. A load item (opcode 0)
// moves the next color to the base and takes new_red/green/blue as the next
// color. A probe item (opcode 1) adds probe_count * pulse_gain to the
// brightness level, clipped at brightness_ceiling, and adds probe_count to a
// saturating 16-bit probe total. A tick item (opcode 2) first rolls the
// palette over to the supplied color once the probe total reaches
// progress_span (clearing the total), then blends each channel from base
// toward next by probe_total / progress_span truncated toward zero, and every
// decay_interval ticks lowers the level by decay_step, floored at zero.
// Opcode 3 changes nothing. Each result carries the blended color, the
// brightness (for a tick, the level before that tick's decay) and
// color_progress = probe_total * progress_scale / progress_span, clipped at
// 255. Items are processed one at a time by a shared 8x16 multiplier and a
// radix-4 restoring divider that runs once per color channel on a tick and
// once for the progress value on every item; each division runs a multiply,
// four two-bit steps and a write back. The result sits in an output
// register, so a new item is accepted while the previous result waits on
// result_stall. Configuration writes (cfg_index 0..5, data in cfg_data) are
// taken while the engine is idle; item_stall is high and cfg_ready low
// while an item is in flight.
`default_nettype none

module led_pulse_fade_color_blender (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // item channel
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic [1:0]                       opcode,
  input  wire logic [7:0]                       probe_count,
  input  wire logic [7:0]                       new_red,
  input  wire logic [7:0]                       new_green,
  input  wire logic [7:0]                       new_blue,
  // result channel
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [7:0]                            red,
  output logic [7:0]                            green,
  output logic [7:0]                            blue,
  output logic [7:0]                            brightness,
  output logic [7:0]                            color_progress,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lpfcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpfcb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lpfcb_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register file; writes land only while the controller is idle
  lpfcb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: apply, level update on a probe, divider lanes, then emit
  lpfcb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_ready    (cfg_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Engine state, shared multiplier, divider and output register
  lpfcb_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .opcode         (opcode),
    .probe_count    (probe_count),
    .new_red        (new_red),
    .new_green      (new_green),
    .new_blue       (new_blue),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .brightness     (brightness),
    .color_progress (color_progress)
  );

endmodule

`default_nettype wire

### design/lpfcb_cfg.sv
`default_nettype none

module lpfcb_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [lpfcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpfcb_pkg::CFG_DATA_W-1:0] cfg_data,
  output lpfcb_pkg::cfg_t                       cfg
);
  import lpfcb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PULSE_GAIN:     cfg.pulse_gain         <= cfg_data[7:0];
        REG_CEILING:        cfg.brightness_ceiling <= cfg_data[7:0];
        REG_DECAY_STEP:     cfg.decay_step         <= cfg_data[7:0];
        REG_DECAY_INTERVAL: cfg.decay_interval     <= cfg_data;
        REG_PROGRESS_SPAN:  cfg.progress_span      <= cfg_data;
        REG_PROGRESS_SCALE: cfg.progress_scale     <= cfg_data[7:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

`default_nettype wire

### design/lpfcb_ctrl.sv
`default_nettype none

module lpfcb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic                        cfg_ready,
  input  wire lpfcb_pkg::dp_status_t  status,
  output lpfcb_pkg::ctrl_cmd_t        cmd
);
  import lpfcb_pkg::*;

  state_t state, state_next;
  lane_t  lane, lane_next;
  step_t  step, step_next;
  logic   result_valid_next;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lane         <= LANE_RED;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      lane         <= lane_next;
      step         <= step_next;
      result_valid <= result_valid_next;
    end
  end

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    lane_next  = lane;
    step_next  = step;
    cmd        = '0;
    cmd.lane   = lane;

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (status.is_probe) begin
          state_next = S_LEVEL;
        end else begin
          state_next = S_MUL;
          lane_next  = status.is_tick ? LANE_RED : LANE_PROG;
        end
      end
      S_LEVEL: begin
        cmd.level_upd = 1'b1;
        lane_next     = LANE_PROG;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        step_next  = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (step == '0);
        step_next     = step + 2'd1;
        if (step == STEP_LAST) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (lane == LANE_PROG) begin
          state_next = S_FIN;
        end else begin
          lane_next  = lane + 2'd1;
          state_next = S_MUL;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

endmodule

`default_nettype wire

### design/lpfcb_dp.sv
`default_nettype none

module lpfcb_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [1:0]            opcode,
  input  wire logic [7:0]            probe_count,
  input  wire logic [7:0]            new_red,
  input  wire logic [7:0]            new_green,
  input  wire logic [7:0]            new_blue,
  input  wire lpfcb_pkg::cfg_t       cfg,
  input  wire lpfcb_pkg::ctrl_cmd_t  cmd,
  output lpfcb_pkg::dp_status_t      status,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue,
  output logic [7:0]                 brightness,
  output logic [7:0]                 color_progress
);
  import lpfcb_pkg::*;

  // Captured item
  logic [1:0]  op;
  logic [7:0]  cnt;
  logic [23:0] fresh;

  // Engine state
  logic [23:0] base_color, next_color, current_color;
  logic [7:0]  level;
  logic [15:0] probe_total;
  logic [15:0] ticks_since_decay;

  // Working registers
  logic [7:0]  shown;
  logic [7:0]  progress;
  logic [23:0] acc;
  logic [7:0]  quo;
  logic        div_zero, div_sat;

  logic [7:0]  base_ch, next_ch, mag, qv, blend;
  logic        neg;
  logic [7:0]  mul_a;
  logic [15:0] mul_b;
  logic [23:0] prod;
  logic [16:0] pt_sum, lvl_sum;
  logic [15:0] pt_sat;
  logic [7:0]  lvl_new;
  logic [15:0] tsd_inc;
  logic [16:0] span_x, t1, d1, t2, d2;
  logic        ge1, ge2;

  function automatic logic [7:0] get_chan(input logic [23:0] c, input lane_t l);
    logic [7:0] v;
    unique case (l)
      LANE_RED:   v = c[23:16];
      LANE_GREEN: v = c[15:8];
      default:    v = c[7:0];
    endcase
    return v;
  endfunction

  assign status.is_tick  = (op == OP_TICK);
  assign status.is_probe = (op == OP_PROBE);

  // Channel difference as sign and magnitude
  assign base_ch = get_chan(base_color, cmd.lane);
  assign next_ch = get_chan(next_color, cmd.lane);
  assign neg     = (next_ch < base_ch);
  assign mag     = neg ? (base_ch - next_ch) : (next_ch - base_ch);

  // Shared 8x16 multiplier: pulse product at apply, numerators otherwise
  always_comb begin
    if (cmd.apply) begin
      mul_a = cnt;
      mul_b = {8'b0, cfg.pulse_gain};
    end else begin
      mul_a = (cmd.lane == LANE_PROG) ? cfg.progress_scale : mag;
      mul_b = probe_total;
    end
  end
  assign prod = {16'b0, mul_a} * {8'b0, mul_b};

  assign pt_sum  = {1'b0, probe_total} + {9'b0, cnt};
  assign pt_sat  = pt_sum[16] ? 16'hFFFF : pt_sum[15:0];
  assign lvl_sum = {9'b0, level} + {1'b0, acc[15:0]};
  assign lvl_new = (lvl_sum > {9'b0, cfg.brightness_ceiling}) ?
                   cfg.brightness_ceiling : lvl_sum[7:0];
  assign tsd_inc = (ticks_since_decay == 16'hFFFF) ? ticks_since_decay :
                   ticks_since_decay + 16'd1;

  // Radix-4 restoring step: two quotient bits per cycle
  assign span_x = {1'b0, cfg.progress_span};
  assign t1     = {acc[23:8], acc[7]};
  assign ge1    = (t1 >= span_x);
  assign d1     = ge1 ? (t1 - span_x) : t1;
  assign t2     = {d1[15:0], acc[6]};
  assign ge2    = (t2 >= span_x);
  assign d2     = ge2 ? (t2 - span_x) : t2;

  assign qv    = div_zero ? 8'd0 : (div_sat ? 8'd255 : quo);
  assign blend = neg ? (base_ch - qv) : (base_ch + qv);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_color        <= '0;
      next_color        <= '0;
      current_color     <= '0;
      level             <= '0;
      probe_total       <= '0;
      ticks_since_decay <= '0;
    end else begin
      if (cmd.apply) begin
        unique case (op)
          OP_LOAD: begin
            base_color <= next_color;
            next_color <= fresh;
          end
          OP_PROBE: probe_total <= pt_sat;
          OP_TICK: begin
            if (probe_total >= cfg.progress_span) begin
              probe_total <= '0;
              base_color  <= next_color;
              next_color  <= fresh;
            end
            if (tsd_inc >= cfg.decay_interval) begin
              ticks_since_decay <= '0;
              level <= (level >= cfg.decay_step) ? (level - cfg.decay_step) : 8'd0;
            end else begin
              ticks_since_decay <= tsd_inc;
            end
          end
          default: ;  // unused opcode leaves the state alone
        endcase
      end
      if (cmd.level_upd && op == OP_PROBE) begin
        level <= lvl_new;
      end
      if (cmd.store) begin
        unique case (cmd.lane)
          LANE_RED:   current_color[23:16] <= blend;
          LANE_GREEN: current_color[15:8]  <= blend;
          LANE_BLUE:  current_color[7:0]   <= blend;
          LANE_PROG:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= opcode;
      cnt   <= probe_count;
      fresh <= {new_red, new_green, new_blue};
    end

    // Level shown with the result is taken before a tick's decay
    if (cmd.apply) begin
      shown <= level;
    end else if (cmd.level_upd && op == OP_PROBE) begin
      shown <= lvl_new;
    end

    if (cmd.apply || cmd.mul) begin
      acc <= prod;
    end else if (cmd.div_step) begin
      acc <= {d2[15:0], acc[5:0], 2'b00};
    end

    if (cmd.div_first) begin
      div_zero <= (acc == '0);
      div_sat  <= (acc[23:8] >= cfg.progress_span);
    end
    if (cmd.div_step) begin
      quo <= {quo[5:0], ge1, ge2};
    end

    if (cmd.store && cmd.lane == LANE_PROG) begin
      progress <= qv;
    end

    if (cmd.emit) begin
      red            <= current_color[23:16];
      green          <= current_color[15:8];
      blue           <= current_color[7:0];
      brightness     <= shown;
      color_progress <= progress;
    end
  end

endmodule

`default_nettype wire

### design/lpfcb_checker.sv
`default_nettype none

module lpfcb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_stall,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue,
  input wire logic [7:0] brightness,
  input wire logic [7:0] color_progress,
  input wire logic       cfg_ready
);

  // Hold a stalled result beat
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(red) && $stable(green) &&
      $stable(blue) && $stable(brightness) && $stable(color_progress))
    else $error("stalled result beat changed");

  // One item in flight: stall right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while the previous one is in flight");

  // Configuration is open exactly when the item side is open
  a_cfg_when_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready != item_stall)
    else $error("cfg_ready out of step with item_stall");

  // A result never follows its item in the very next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> !$rose(result_valid))
    else $error("result appeared one cycle after acceptance");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind led_pulse_fade_color_blender lpfcb_checker u_lpfcb_checker (.*);

`default_nettype wire

### sim/tb_top.sv
module tb_top;
  import lpfcb_pkg::*;

  // Opcode 3 has no name in the package; the block must treat it as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned BEATS_PER_PHASE = 110;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
    logic [7:0] color_progress;
  } pixel_t;

  // One line of the directed script: either an item or a register write
  typedef struct {
    bit                   is_reg;
    logic [1:0]           op;
    logic [7:0]           cnt;
    logic [23:0]          rgb;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
    bit                   typed;
    pixel_t               want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [1:0]            opcode = OP_LOAD;
  logic [7:0]            probe_count = '0;
  logic [7:0]            new_red = '0;
  logic [7:0]            new_green = '0;
  logic [7:0]            new_blue = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic [7:0]            brightness;
  logic [7:0]            color_progress;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the engine: registers and state as the block should hold them
  cfg_t        cfg_m = CFG_RESET;
  logic [23:0] base_rgb = '0;
  logic [23:0] next_rgb = '0;
  logic [23:0] mix_rgb = '0;
  logic [7:0]  glow = '0;
  logic [15:0] probe_sum = '0;
  logic [15:0] tick_run = '0;

  pixel_t      awaited_pixels[$];
  stim_row_t   script[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  led_pulse_fade_color_blender i_dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .opcode         (opcode),
    .probe_count    (probe_count),
    .new_red        (new_red),
    .new_green      (new_green),
    .new_blue       (new_blue),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .brightness     (brightness),
    .color_progress (color_progress),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Blend one channel from base toward next by probe_sum / span, truncated toward zero
  function automatic logic [7:0] mix_channel(input logic [7:0] from_c, input logic [7:0] to_c);
    int diff;
    int r;
    if (cfg_m.progress_span == 16'd0) return from_c;
    diff = int'(to_c) - int'(from_c);
    r = int'(from_c) + (diff * int'(probe_sum)) / int'(cfg_m.progress_span);
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r[7:0];
  endfunction

  // Advance the shadow engine by one item and return the pixel it reports
  function automatic pixel_t blend_step(input logic [1:0] op, input logic [7:0] cnt,
                                        input logic [23:0] fresh);
    int unsigned sum;
    int unsigned total;
    int unsigned num;
    int unsigned q;
    logic [7:0]  shown;
    shown = glow;
    case (op)
      OP_LOAD: begin
        base_rgb = next_rgb;
        next_rgb = fresh;
      end
      OP_PROBE: begin
        sum = glow + cnt * cfg_m.pulse_gain;
        total = probe_sum + cnt;
        probe_sum = (total > 32'hFFFF) ? 16'hFFFF : total[15:0];
        // clip also pulls a level above a lowered ceiling back down
        glow = (sum > cfg_m.brightness_ceiling) ? cfg_m.brightness_ceiling : sum[7:0];
        shown = glow;
      end
      OP_TICK: begin
        if (probe_sum >= cfg_m.progress_span) begin
          probe_sum = '0;
          base_rgb = next_rgb;
          next_rgb = fresh;
        end
        mix_rgb = {mix_channel(base_rgb[23:16], next_rgb[23:16]),
                   mix_channel(base_rgb[15:8], next_rgb[15:8]),
                   mix_channel(base_rgb[7:0], next_rgb[7:0])};
        // report the level before this tick's decay
        shown = glow;
        if (tick_run != 16'hFFFF) tick_run++;
        if (tick_run >= cfg_m.decay_interval) begin
          tick_run = '0;
          glow = (glow >= cfg_m.decay_step) ? glow - cfg_m.decay_step : 8'd0;
        end
      end
      default: ;
    endcase
    num = probe_sum * cfg_m.progress_scale;
    if (cfg_m.progress_span == 16'd0) begin
      q = (num != 0) ? 255 : 0;
    end else begin
      q = num / cfg_m.progress_span;
      if (q > 255) q = 255;
    end
    return {mix_rgb, shown, q[7:0]};
  endfunction

  function automatic stim_row_t item_line(input logic [1:0] op, input logic [7:0] cnt,
                                          input logic [23:0] rgb, input bit typed = 1'b0,
                                          input pixel_t want = '0);
    stim_row_t r;
    r.is_reg = 1'b0;
    r.op = op;
    r.cnt = cnt;
    r.rgb = rgb;
    r.idx = '0;
    r.data = '0;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t reg_line(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [15:0] data);
    stim_row_t r;
    r.is_reg = 1'b1;
    r.op = OP_LOAD;
    r.cnt = '0;
    r.rgb = '0;
    r.idx = idx;
    r.data = data;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // Mostly short bursts, now and then a long one
  function automatic int unsigned burst_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned idle_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 99) < 50) return 0;
    return burst_len();
  endfunction

  // Offer one beat, hold it until taken, record what it should produce, then drop valid
  task automatic send_item(input logic [1:0] op, input logic [7:0] cnt, input logic [23:0] rgb,
                           input bit typed, input pixel_t want);
    int unsigned gap;
    pixel_t      predicted;
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    opcode <= op;
    probe_count <= cnt;
    new_red <= rgb[23:16];
    new_green <= rgb[15:8];
    new_blue <= rgb[7:0];
    do @(posedge clk); while (item_stall);
    predicted = blend_step(op, cnt, rgb);
    awaited_pixels.push_back(typed ? want : predicted);
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PULSE_GAIN:     cfg_m.pulse_gain = data[7:0];
      REG_CEILING:        cfg_m.brightness_ceiling = data[7:0];
      REG_DECAY_STEP:     cfg_m.decay_step = data[7:0];
      REG_DECAY_INTERVAL: cfg_m.decay_interval = data;
      REG_PROGRESS_SPAN:  cfg_m.progress_span = data;
      REG_PROGRESS_SCALE: cfg_m.progress_scale = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver: stall in bursts, starting no new burst while quiet
  always @(negedge clk) begin
    if (stall_left != 0) stall_left--;
    else if (!quiet && $urandom_range(0, 99) < 20) stall_left = burst_len();
    result_stall <= (stall_left != 0);
  end

  // Compare every result beat against the oldest expectation
  always @(posedge clk) begin : result_check
    pixel_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %0d %0d %0d %0d %0d",
                 $time, red, green, blue, brightness, color_progress);
      end else begin
        want = awaited_pixels.pop_front();
        check_field("red", red, want.red);
        check_field("green", green, want.green);
        check_field("blue", blue, want.blue);
        check_field("brightness", brightness, want.brightness);
        check_field("color_progress", color_progress, want.color_progress);
      end
    end
  end

  // Watchdog: bail out on a hang
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t        c;
    logic [1:0]  op;
    logic [7:0]  cnt;
    int unsigned r;

    // Directed script, run under reset settings unless a row rewrites a register.
    // Rows with a typed result are easy to work out by hand; the rest use the shadow.
    script.push_back(item_line(OP_TICK, 8'd0, 24'h000000, 1'b1, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0}));
    script.push_back(item_line(OP_LOAD, 8'd0, 24'hFFFFFF, 1'b1, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0}));
    script.push_back(item_line(OP_PROBE, 8'd0, 24'hFFFFFF, 1'b1,
                               {8'd0, 8'd0, 8'd0, 8'd0, 8'd0}));
    // full count saturates both the level and the reported progress
    script.push_back(item_line(OP_PROBE, 8'd255, 24'h000000, 1'b1,
                               {8'd0, 8'd0, 8'd0, 8'd255, 8'd255}));
    // total past the span: roll over, blend lands on the old next color
    script.push_back(item_line(OP_TICK, 8'd0, 24'h000000, 1'b1,
                               {8'hFF, 8'hFF, 8'hFF, 8'd255, 8'd0}));
    script.push_back(item_line(OP_PROBE, 8'd50, 24'h000000));
    script.push_back(item_line(OP_TICK, 8'd0, 24'hAA550F));
    script.push_back(item_line(OP_UNUSED, 8'hFF, 24'hFFFFFF));
    script.push_back(item_line(OP_LOAD, 8'd0, 24'h123456));
    script.push_back(item_line(OP_TICK, 8'd0, 24'h000000));
    // lower the ceiling under the level, then probe with nothing to add
    script.push_back(reg_line(REG_CEILING, 16'd40));
    script.push_back(item_line(OP_PROBE, 8'd0, 24'h000000));
    script.push_back(reg_line(REG_PULSE_GAIN, 16'd0));
    script.push_back(item_line(OP_PROBE, 8'd255, 24'h000000));
    // decay on every tick, by more than the level holds
    script.push_back(reg_line(REG_DECAY_INTERVAL, 16'd0));
    script.push_back(reg_line(REG_DECAY_STEP, 16'd255));
    script.push_back(item_line(OP_TICK, 8'd0, 24'h0F0F0F));
    script.push_back(item_line(OP_TICK, 8'd0, 24'hF0F0F0));
    // zero span: every tick rolls over, progress is all or nothing
    script.push_back(reg_line(REG_PROGRESS_SPAN, 16'd0));
    script.push_back(reg_line(REG_PROGRESS_SCALE, 16'd0));
    script.push_back(item_line(OP_TICK, 8'd0, 24'h80C0FF));
    script.push_back(item_line(OP_PROBE, 8'd7, 24'h000000));
    script.push_back(reg_line(REG_PROGRESS_SCALE, 16'd255));
    script.push_back(item_line(OP_PROBE, 8'd1, 24'h000000));
    script.push_back(item_line(OP_TICK, 8'd0, 24'h010203));
    script.push_back(item_line(OP_TICK, 8'd0, 24'hFEDCBA));
    // widest settings
    script.push_back(reg_line(REG_PROGRESS_SPAN, 16'hFFFF));
    script.push_back(reg_line(REG_DECAY_INTERVAL, 16'hFFFF));
    script.push_back(reg_line(REG_PULSE_GAIN, 16'd255));
    script.push_back(reg_line(REG_CEILING, 16'd255));
    script.push_back(reg_line(REG_DECAY_STEP, 16'd1));
    script.push_back(item_line(OP_PROBE, 8'd255, 24'h000000));
    script.push_back(item_line(OP_TICK, 8'd0, 24'h000000));
    script.push_back(item_line(OP_LOAD, 8'd0, 24'h000000));

    // Hold reset, then release it on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        drain_results();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_item(script[i].op, script[i].cnt, script[i].rgb, script[i].typed, script[i].want);
      end
    end

    // Random phases, each under its own register settings
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: c = '{8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255};
        1: c = '{8'd0, 8'd0, 8'd0, 16'd1, 16'd1, 8'd0};
        2: c = CFG_RESET;
        default: begin
          c.pulse_gain = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 24));
          c.brightness_ceiling = 8'($urandom);
          c.decay_step = 8'($urandom_range(0, 8));
          c.decay_interval = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                         : 16'($urandom_range(1, 12));
          c.progress_span = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                        : 16'($urandom_range(1, 300));
          c.progress_scale = 8'($urandom);
        end
      endcase
      // one phase runs flat out on both sides
      quiet = (p == 3);
      drain_results();
      write_reg(REG_PULSE_GAIN, 16'(c.pulse_gain));
      write_reg(REG_CEILING, 16'(c.brightness_ceiling));
      write_reg(REG_DECAY_STEP, 16'(c.decay_step));
      write_reg(REG_DECAY_INTERVAL, c.decay_interval);
      write_reg(REG_PROGRESS_SPAN, c.progress_span);
      write_reg(REG_PROGRESS_SCALE, 16'(c.progress_scale));

      for (int unsigned n = 0; n < BEATS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 10) op = OP_LOAD;
        else if (r < 45) op = OP_PROBE;
        else if (r < 95) op = OP_TICK;
        else op = OP_UNUSED;
        // small counts keep blends partial; full range now and then
        cnt = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        send_item(op, cnt, 24'($urandom), 1'b0, '0);
        // occasionally hold off until the engine has caught up
        if ($urandom_range(0, 99) < 2) drain_results();
      end
    end

    drain_results();
    // leave room for any stray beat to show up
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
design/lpfcb_pkg.sv
design/lpfcb_cfg.sv
design/lpfcb_ctrl.sv
design/lpfcb_dp.sv
design/led_pulse_fade_color_blender.sv
design/lpfcb_checker.sv
sim/tb_top.sv
